// ===== src/regpt_pkg.sv =====
// Types, byte codes and token helpers shared by the regex pattern tokenizer.
package regpt_pkg;

    typedef enum logic [3:0] {
        KIND_CHAR   = 4'd0,
        KIND_OPT    = 4'd1,
        KIND_STAR   = 4'd2,
        KIND_PLUS   = 4'd3,
        KIND_ALT    = 4'd4,
        KIND_OPEN   = 4'd5,
        KIND_CLOSE  = 4'd6,
        KIND_CONCAT = 4'd7,
        KIND_END    = 4'd8
    } token_kind_t;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_CARET   = 5'b00010,
        MODE_ESCAPE  = 5'b00100,
        MODE_PENDING = 5'b01000,
        MODE_DASH    = 5'b10000
    } scan_mode_t;

    typedef struct packed {
        scan_mode_t mode;
        logic [7:0] pend_low;
        logic       pend_comp;
        logic       prev_ends;
    } scan_state_t;

    typedef struct packed {
        logic        comp;
        logic [7:0]  hi;
        logic [7:0]  lo;
        token_kind_t kind;
    } token_t;

    localparam int MAX_TOKENS = 3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CTL_LF    = 8'd10;
    localparam logic [7:0] CTL_CR    = 8'd13;
    localparam logic [7:0] CTL_TAB   = 8'd9;

    localparam scan_state_t STATE_CLEAR = '{MODE_IDLE, 8'h00, 1'b0, 1'b0};

    function automatic token_t op_tok(token_kind_t kind);
        token_t t;
        t.kind = kind;
        t.lo   = 8'h00;
        t.hi   = 8'h00;
        t.comp = 1'b0;
        return t;
    endfunction

    function automatic token_t char_tok(logic [7:0] lo, logic [7:0] hi, logic comp);
        token_t t;
        t.kind = KIND_CHAR;
        t.lo   = lo;
        t.hi   = hi;
        t.comp = comp;
        return t;
    endfunction

endpackage

// ===== src/regpt_decode.sv =====
// Per-byte decode: scan state and one pattern byte in, up to three tokens out.
module regpt_decode (
    input  regpt_pkg::scan_state_t st,
    input  logic [7:0]             pattern_byte,
    output regpt_pkg::scan_state_t st_next,
    output regpt_pkg::token_t      tok [regpt_pkg::MAX_TOKENS],
    output logic [1:0]             tok_cnt
);
    import regpt_pkg::*;

    always_comb begin
        logic [1:0] n;
        logic       do_idle;
        logic [7:0] b;
        logic [7:0] ctl;

        b       = pattern_byte;
        n       = 2'd0;
        do_idle = 1'b0;
        ctl     = CTL_TAB;
        st_next = st;
        for (int i = 0; i < MAX_TOKENS; i++) begin
            tok[i] = op_tok(KIND_END);
        end

        case (st.mode)
            MODE_CARET: begin
                if (b == CH_NUL) begin
                    tok[n] = op_tok(KIND_END); n = n + 2'd1;
                    st_next = STATE_CLEAR;
                end else begin
                    if (st.prev_ends) begin
                        tok[n] = op_tok(KIND_CONCAT); n = n + 2'd1;
                    end
                    st_next = '{MODE_PENDING, b, 1'b1, 1'b1};
                end
            end
            MODE_ESCAPE: begin
                if (b == CH_NUL) begin
                    tok[n] = op_tok(KIND_END); n = n + 2'd1;
                    st_next = STATE_CLEAR;
                end else if (b == CH_N || b == CH_R || b == CH_T) begin
                    ctl = (b == CH_N) ? CTL_LF : (b == CH_R) ? CTL_CR : CTL_TAB;
                    if (st.prev_ends) begin
                        tok[n] = op_tok(KIND_CONCAT); n = n + 2'd1;
                    end
                    tok[n] = char_tok(ctl, ctl, 1'b0); n = n + 2'd1;
                    st_next.prev_ends = 1'b1;
                    st_next.mode      = MODE_IDLE;
                end else begin
                    if (st.prev_ends) begin
                        tok[n] = op_tok(KIND_CONCAT); n = n + 2'd1;
                    end
                    st_next = '{MODE_PENDING, b, 1'b0, 1'b1};
                end
            end
            MODE_PENDING: begin
                if (b == CH_DASH) begin
                    st_next.mode = MODE_DASH;
                end else begin
                    tok[n] = char_tok(st.pend_low, st.pend_low, st.pend_comp);
                    n = n + 2'd1;
                    st_next.prev_ends = 1'b1;
                    do_idle = 1'b1;
                end
            end
            MODE_DASH: begin
                tok[n] = char_tok(st.pend_low, b, st.pend_comp); n = n + 2'd1;
                st_next.prev_ends = 1'b1;
                st_next.mode      = MODE_IDLE;
                if (b == CH_NUL) begin
                    tok[n] = op_tok(KIND_END); n = n + 2'd1;
                    st_next = STATE_CLEAR;
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // plain byte handling, also reached after flushing a pending char
        if (do_idle) begin
            st_next.mode = MODE_IDLE;
            case (b)
                CH_NUL: begin
                    tok[n] = op_tok(KIND_END); n = n + 2'd1;
                    st_next = STATE_CLEAR;
                end
                CH_QMARK: begin
                    tok[n] = op_tok(KIND_OPT); n = n + 2'd1;
                    st_next.prev_ends = 1'b1;
                end
                CH_STAR: begin
                    tok[n] = op_tok(KIND_STAR); n = n + 2'd1;
                    st_next.prev_ends = 1'b1;
                end
                CH_PLUS: begin
                    tok[n] = op_tok(KIND_PLUS); n = n + 2'd1;
                    st_next.prev_ends = 1'b1;
                end
                CH_BAR: begin
                    tok[n] = op_tok(KIND_ALT); n = n + 2'd1;
                    st_next.prev_ends = 1'b0;
                end
                CH_LPAREN: begin
                    if (st_next.prev_ends) begin
                        tok[n] = op_tok(KIND_CONCAT); n = n + 2'd1;
                    end
                    tok[n] = op_tok(KIND_OPEN); n = n + 2'd1;
                    st_next.prev_ends = 1'b0;
                end
                CH_RPAREN: begin
                    tok[n] = op_tok(KIND_CLOSE); n = n + 2'd1;
                    st_next.prev_ends = 1'b1;
                end
                CH_CARET: begin
                    st_next.mode = MODE_CARET;
                end
                CH_BSLASH: begin
                    st_next.mode = MODE_ESCAPE;
                end
                default: begin
                    if (st_next.prev_ends) begin
                        tok[n] = op_tok(KIND_CONCAT); n = n + 2'd1;
                    end
                    st_next.mode      = MODE_PENDING;
                    st_next.pend_low  = b;
                    st_next.pend_comp = 1'b0;
                    st_next.prev_ends = 1'b1;
                end
            endcase
        end

        tok_cnt = n;
    end

endmodule

// ===== src/regex_pattern_tokenizer_core.sv =====
// Top level of the regex pattern tokenizer: stream ports, token buffer and output register.
//
// Takes one pattern byte per word and emits the tokens it causes, one token per output
// word, with tlast on the final token of each byte. A byte is taken every cycle as long as
// each byte yields at most one token and m_tready is high; a byte yielding more tokens (up
// to three, e.g. a flushed character, CONCAT and an open group) holds the input while the
// buffer drains one word per cycle with m_tready high, until one is left. Tokens pass the
// buffer, then the output register. A plain character appears only once the next byte
// shows whether a range follows; byte 0 ends the pattern with END and resets the scanner.
module regex_pattern_tokenizer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pattern_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] token_kind, [11:4] range_low,
                                   // [19:12] range_high, [20] complemented, [23:21] zero
    output logic        m_tlast    // last_of_run
);
    import regpt_pkg::*;

    scan_state_t st_reg, st_next;
    token_t      dec_tok [MAX_TOKENS];
    logic [1:0]  dec_cnt;

    token_t      grp_reg [MAX_TOKENS];
    token_t      grp_next [MAX_TOKENS];
    logic [1:0]  grp_cnt_reg, grp_cnt_next;

    token_t      out_tok_reg, out_tok_next;
    logic        out_last_reg, out_last_next;
    logic        out_valid_reg, out_valid_next;

    logic        in_word;
    logic        out_load;
    logic        move;

    regpt_decode u_decode (
        .st           (st_reg),
        .pattern_byte (s_tdata),
        .st_next      (st_next),
        .tok          (dec_tok),
        .tok_cnt      (dec_cnt)
    );

    assign out_load = !out_valid_reg || m_tready;
    assign move     = out_load && (grp_cnt_reg != 2'd0);
    assign s_tready = (grp_cnt_reg == 2'd0) || ((grp_cnt_reg == 2'd1) && out_load);
    assign in_word  = s_tvalid && s_tready;

    always_comb begin
        grp_next     = grp_reg;
        grp_cnt_next = grp_cnt_reg;
        if (in_word) begin
            grp_next     = dec_tok;
            grp_cnt_next = dec_cnt;
        end else if (move) begin
            grp_next[0]  = grp_reg[1];
            grp_next[1]  = grp_reg[2];
            grp_cnt_next = grp_cnt_reg - 2'd1;
        end
    end

    always_comb begin
        out_tok_next   = out_tok_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;
        if (move) begin
            out_tok_next   = grp_reg[0];
            out_last_next  = (grp_cnt_reg == 2'd1);
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= STATE_CLEAR;
            grp_cnt_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_word) begin
                st_reg <= st_next;
            end
            grp_cnt_reg   <= grp_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg      <= grp_next;
        out_tok_reg  <= out_tok_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_tok_reg.comp, out_tok_reg.hi, out_tok_reg.lo,
                       out_tok_reg.kind};
    assign m_tlast  = out_last_reg;

endmodule

// ===== tb/sv/tb_regex_pattern_tokenizer_core.sv =====
// Testbench for the regex pattern tokenizer core: token scoreboard, stream drivers and checks.
`timescale 1ns / 1ps

module tb_regex_pattern_tokenizer_core;
    import regpt_pkg::*;

    localparam int RANDOM_BYTES = 240;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    // Predicts the token stream from accepted pattern bytes and checks the output words.
    class token_scoreboard;
        typedef struct {
            token_t tok;
            logic   last;
        } expected_t;

        expected_t  expected_tokens[$];
        token_t     step_buf[$];
        scan_mode_t mode;
        logic [7:0] pend_low;
        logic       pend_comp;
        logic       prev_ends;
        int         errors;
        int         tokens_checked;
        int         patterns_ended;

        function new();
            clear_scan();
            errors         = 0;
            tokens_checked = 0;
            patterns_ended = 0;
        endfunction

        function void clear_scan();
            mode      = MODE_IDLE;
            pend_low  = 8'h00;
            pend_comp = 1'b0;
            prev_ends = 1'b0;
        endfunction

        function void emit(token_kind_t kind, logic [7:0] lo, logic [7:0] hi, logic comp);
            token_t t;
            t.kind = kind;
            t.lo   = lo;
            t.hi   = hi;
            t.comp = comp;
            if (step_buf.size() < MAX_TOKENS)
                step_buf.push_back(t);
        endfunction

        function void concat_if_ends();
            if (prev_ends)
                emit(KIND_CONCAT, 8'h00, 8'h00, 1'b0);
        endfunction

        function void end_pattern();
            emit(KIND_END, 8'h00, 8'h00, 1'b0);
            clear_scan();
            patterns_ended++;
        endfunction

        // CONCAT is decided when the character is seen; the char itself waits for a dash check
        function void hold_char(logic [7:0] b, logic comp);
            concat_if_ends();
            pend_low  = b;
            pend_comp = comp;
            prev_ends = 1'b1;
            mode      = MODE_PENDING;
        endfunction

        function void operator_token(token_kind_t kind);
            if (kind == KIND_OPEN)
                concat_if_ends();
            emit(kind, 8'h00, 8'h00, 1'b0);
            prev_ends = (kind == KIND_OPT || kind == KIND_STAR ||
                         kind == KIND_PLUS || kind == KIND_CLOSE);
        endfunction

        function void scan_plain(logic [7:0] b);
            mode = MODE_IDLE;
            case (b)
                CH_NUL:    end_pattern();
                CH_QMARK:  operator_token(KIND_OPT);
                CH_STAR:   operator_token(KIND_STAR);
                CH_PLUS:   operator_token(KIND_PLUS);
                CH_BAR:    operator_token(KIND_ALT);
                CH_LPAREN: operator_token(KIND_OPEN);
                CH_RPAREN: operator_token(KIND_CLOSE);
                CH_CARET:  mode = MODE_CARET;
                CH_BSLASH: mode = MODE_ESCAPE;
                default:   hold_char(b, 1'b0);
            endcase
        endfunction

        // Works out the tokens one accepted byte causes and queues them in order.
        function void tokenize_byte(logic [7:0] b);
            logic [7:0] ctl;
            expected_t  e;
            step_buf.delete();
            case (mode)
                MODE_CARET: begin
                    if (b == CH_NUL)
                        end_pattern();
                    else
                        hold_char(b, 1'b1);
                end
                MODE_ESCAPE: begin
                    if (b == CH_NUL) begin
                        end_pattern();
                    end else if (b == CH_N || b == CH_R || b == CH_T) begin
                        ctl = (b == CH_N) ? CTL_LF : (b == CH_R) ? CTL_CR : CTL_TAB;
                        concat_if_ends();
                        emit(KIND_CHAR, ctl, ctl, 1'b0);
                        prev_ends = 1'b1;
                        mode      = MODE_IDLE;
                    end else begin
                        hold_char(b, 1'b0);
                    end
                end
                MODE_PENDING: begin
                    if (b == CH_DASH) begin
                        mode = MODE_DASH;
                    end else begin
                        emit(KIND_CHAR, pend_low, pend_low, pend_comp);
                        prev_ends = 1'b1;
                        scan_plain(b);
                    end
                end
                MODE_DASH: begin
                    // range upper byte is raw, even a terminator
                    emit(KIND_CHAR, pend_low, b, pend_comp);
                    prev_ends = 1'b1;
                    mode      = MODE_IDLE;
                    if (b == CH_NUL)
                        end_pattern();
                end
                default: scan_plain(b);
            endcase
            foreach (step_buf[i]) begin
                e.tok  = step_buf[i];
                e.last = (i == step_buf.size() - 1);
                expected_tokens.push_back(e);
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("MISMATCH @%0t: %s", $realtime, msg);
        endfunction

        function void check_token(logic [23:0] data, logic last);
            expected_t e;
            if (expected_tokens.size() == 0) begin
                report($sformatf("unexpected token word %h last=%b", data, last));
                return;
            end
            e = expected_tokens.pop_front();
            tokens_checked++;
            if (data[3:0] !== e.tok.kind || data[11:4] !== e.tok.lo ||
                data[19:12] !== e.tok.hi || data[20] !== e.tok.comp || last !== e.last)
                report($sformatf({"token %0d: expected kind=%0d lo=%h hi=%h comp=%b last=%b,",
                                  " got kind=%0d lo=%h hi=%h comp=%b last=%b"},
                                 tokens_checked, e.tok.kind, e.tok.lo, e.tok.hi, e.tok.comp,
                                 e.last, data[3:0], data[11:4], data[19:12], data[20], last));
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] pattern_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [3:0] token_kind, [11:4] range_low,
                                     // [19:12] range_high, [20] complemented
    logic        m_tlast;            // last_of_run

    token_scoreboard sb = new();
    bit          idle_enable = 1'b1;
    int          bytes_sent  = 0;
    int          stall_count = 0;

    // caret and backslash before a terminator, terminator after a dash, then a
    // pattern with every operator, a complemented raw range and the control escapes
    logic [7:0] directed [26] = '{
        CH_CARET, CH_NUL,
        CH_BSLASH, CH_NUL,
        8'h61, CH_DASH, CH_NUL,
        8'hFF, CH_LPAREN, CH_CARET, CH_LPAREN, CH_DASH, CH_BSLASH, CH_RPAREN, CH_STAR,
        CH_BSLASH, CH_N, CH_DASH, CH_QMARK, CH_BAR, CH_BSLASH, CH_T, CH_BSLASH, CH_R,
        CH_PLUS, CH_NUL
    };

    regex_pattern_tokenizer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // token sink with random backpressure
    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            sb.check_token(m_tdata, m_tlast);
        m_tready <= !(idle_enable && $urandom_range(0, 99) < 11);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count == STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d tokens outstanding",
                     STALL_LIMIT, sb.expected_tokens.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (idle_enable && $urandom_range(0, 99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.tokenize_byte(b);
        bytes_sent++;
    endtask

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 5))
            0:       return CH_QMARK;
            1:       return CH_STAR;
            2:       return CH_PLUS;
            3:       return CH_BAR;
            4:       return CH_LPAREN;
            default: return CH_RPAREN;
        endcase
    endfunction

    // One mostly well-formed pattern with random content, a little noise mixed in.
    task automatic send_random_pattern();
        int pieces;
        pieces = $urandom_range(1, 8);
        repeat (pieces) begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_byte(8'($urandom_range(1, 255)));
                3, 4:    send_byte(random_operator());
                5: begin
                    send_byte(CH_CARET);
                    send_byte(8'($urandom_range(1, 255)));
                end
                6: begin
                    send_byte(CH_BSLASH);
                    case ($urandom_range(0, 3))
                        0:       send_byte(CH_N);
                        1:       send_byte(CH_R);
                        2:       send_byte(CH_T);
                        default: send_byte(8'($urandom_range(1, 255)));
                    endcase
                end
                7, 8: begin
                    send_byte(8'($urandom_range(1, 255)));
                    send_byte(CH_DASH);
                    send_byte(($urandom_range(0, 30) == 0) ? CH_NUL
                                                           : 8'($urandom_range(1, 255)));
                end
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
        if ($urandom_range(0, 9) != 0)
            send_byte(CH_NUL);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_byte(directed[i]);

        while (bytes_sent < $size(directed) + RANDOM_BYTES) begin
            // a stretch with both sides running flat out
            idle_enable = !(bytes_sent > 110 && bytes_sent < 180);
            send_random_pattern();
        end
        send_byte(CH_NUL);
        s_tvalid    <= 1'b0;
        idle_enable = 1'b1;

        while (sb.expected_tokens.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.expected_tokens.size() != 0)
            sb.report($sformatf("%0d tokens never arrived", sb.expected_tokens.size()));

        $display("Fed %0d pattern bytes (%0d patterns ended), checked %0d tokens.",
                 bytes_sent, sb.patterns_ended, sb.tokens_checked);
        $display("Covered operators, escapes, carets, ranges and terminator corners; %0d errors.",
                 sb.errors);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== regex_pattern_tokenizer_core.f =====
src/regpt_pkg.sv
src/regpt_decode.sv
src/regex_pattern_tokenizer_core.sv
tb/sv/tb_regex_pattern_tokenizer_core.sv
